// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = 32;

  localparam logic [2:0] REG_AC1   = 3'd0;
  localparam logic [2:0] REG_AC2   = 3'd1;
  localparam logic [2:0] REG_AC3   = 3'd2;
  localparam logic [2:0] REG_AC4   = 3'd3;
  localparam logic [2:0] REG_AC56  = 3'd4;
  localparam logic [2:0] REG_B1    = 3'd5;
  localparam logic [2:0] REG_B2    = 3'd6;
  localparam logic [2:0] REG_MCMD  = 3'd7;

  localparam logic [31:0] B6_BIAS      = 32'd4000;
  localparam logic [31:0] B7_SCALE     = 32'd50000;
  localparam logic [31:0] B4_BIAS      = 32'd32768;
  localparam logic [31:0] P_SQ_COEF    = 32'd3038;
  localparam logic [31:0] P_LIN_COEF   = 32'hFFFF_E331;  // -7375
  localparam logic [31:0] P_OFFSET     = 32'd3791;
  localparam logic signed [31:0] P_MAX = 32'sd131071;
  localparam logic signed [31:0] T_MAX = 32'sd32767;
  localparam logic signed [31:0] T_MIN = -32'sd32768;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [16:0]        pressure_pa;
    logic               divide_error;
  } out_t;

  // Calibration set, already sign- or zero-extended to the working width.
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } coef_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

// ===== hdl/barometric_sensor_compensation.sv =====
// Path: stages 1-2, first divider, stages 3-8, second divider, stages 9-10, out_r.
// One reading pair per cycle unless stalled; two 32-stage restoring dividers set depth.
// The whole pipeline advances unless the output register holds a result that is stalled.
// Reset (rst_n low, synchronous) clears all valid bits and all calibration registers.
// Calibration registers sit on the APB port at byte addresses 0x00 to 0x1C.
module barometric_sensor_compensation (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bsc_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bsc_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bsc_pkg::DATA_W-1:0]   pwdata,
  output logic [bsc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import bsc_pkg::*;

  localparam int SB1_W = 32 + 16 + 1 + 1;
  localparam int SB2_W = 16 + 1 + 1;

  coef_t coef;
  logic  en;

  bsc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .coef
  );

  // One global advance: every stage moves together, so a stall at the
  // output freezes each item in place and nothing is dropped or doubled.
  logic out_v_r;
  assign en       = !(out_v_r && out_stall);
  assign in_stall = !en;

  // Stage 1: first temperature term.
  logic        s1_v_r;
  logic [31:0] s1_x1_r;
  logic [15:0] s1_up_r;
  logic [31:0] s1_prod;
  assign s1_prod = ({16'd0, in_data.raw_temperature} - coef.ac6) * coef.ac5;

  // Stage 2: operands of the signed divide, split into magnitudes and sign.
  logic        s2_v_r, s2_err_r, s2_neg_r;
  logic [31:0] s2_x1_r, s2_nmag_r, s2_dmag_r;
  logic [15:0] s2_up_r;
  logic [31:0] s2_den, s2_num;
  assign s2_den = s1_x1_r + coef.md;
  assign s2_num = {coef.mc[20:0], 11'd0};

  // First divider: X2 = (MC << 11) / (X1 + MD).
  logic             d1_v;
  logic [31:0]      d1_q;
  logic [SB1_W-1:0] d1_sb;
  logic [31:0]      d1_x1;
  logic [15:0]      d1_up;
  logic             d1_err, d1_neg;

  bsc_div #(.DW(DIV_W), .SBW(SB1_W)) u_div_temp (
    .clk, .rst_n, .en,
    .in_v   (s2_v_r),
    .num    (s2_nmag_r),
    .den    (s2_dmag_r),
    .in_sb  ({s2_x1_r, s2_up_r, s2_err_r, s2_neg_r}),
    .out_v  (d1_v),
    .quo    (d1_q),
    .out_sb (d1_sb)
  );
  assign {d1_x1, d1_up, d1_err, d1_neg} = d1_sb;

  // Stage 3: B5, the saturated temperature and B6.
  logic        s3_v_r, s3_err_r;
  logic [31:0] s3_b6_r;
  logic [15:0] s3_ts_r, s3_up_r;
  logic [31:0] s3_x2, s3_b5, s3_tw;
  logic [15:0] s3_ts;
  always_comb begin
    s3_x2 = d1_neg ? (32'd0 - d1_q) : d1_q;
    s3_b5 = d1_x1 + s3_x2;
    s3_tw = asr(s3_b5 + 32'd8, 4);
    if ($signed(s3_tw) > T_MAX) begin
      s3_ts = T_MAX[15:0];
    end else if ($signed(s3_tw) < T_MIN) begin
      s3_ts = T_MIN[15:0];
    end else begin
      s3_ts = s3_tw[15:0];
    end
  end

  // Stage 4: B6 squared and the linear products.
  logic        s4_v_r, s4_err_r;
  logic [31:0] s4_sq_r, s4_m2_r, s4_m3_r;
  logic [15:0] s4_ts_r, s4_up_r;
  logic [31:0] s4_b6sq;
  assign s4_b6sq = s3_b6_r * s3_b6_r;

  // Stage 5: quadratic offset and sensitivity terms.
  logic        s5_v_r, s5_err_r;
  logic [31:0] s5_x3_r, s5_xs_r;
  logic [15:0] s5_ts_r, s5_up_r;
  logic [31:0] s5_p2, s5_p1;
  assign s5_p2 = coef.b2 * s4_sq_r;
  assign s5_p1 = coef.b1 * s4_sq_r;

  // Stage 6: B3, with division by four rounding toward zero.
  logic        s6_v_r, s6_err_r;
  logic [31:0] s6_b3_r, s6_x3_r;
  logic [15:0] s6_ts_r, s6_up_r;
  logic [31:0] s6_sum;
  assign s6_sum = {coef.ac1[29:0], 2'b00} + s5_x3_r + 32'd2;

  // Stage 7: B4 and B7.
  logic        s7_v_r, s7_err_r;
  logic [31:0] s7_b4_r, s7_b7_r;
  logic [15:0] s7_ts_r;
  logic [31:0] s7_b4p, s7_b7;
  assign s7_b4p = coef.ac4 * (s6_x3_r + B4_BIAS);
  assign s7_b7  = ({16'd0, s6_up_r} - s6_b3_r) * B7_SCALE;

  // Stage 8: choose the overflow-safe ordering of the pressure divide.
  logic        s8_v_r, s8_err_r, s8_big_r;
  logic [31:0] s8_dvd_r, s8_b4_r;
  logic [15:0] s8_ts_r;

  logic             d2_v;
  logic [31:0]      d2_q;
  logic [SB2_W-1:0] d2_sb;
  logic [15:0]      d2_ts;
  logic             d2_err, d2_big;

  bsc_div #(.DW(DIV_W), .SBW(SB2_W)) u_div_press (
    .clk, .rst_n, .en,
    .in_v   (s8_v_r),
    .num    (s8_dvd_r),
    .den    (s8_b4_r),
    .in_sb  ({s8_ts_r, s8_err_r, s8_big_r}),
    .out_v  (d2_v),
    .quo    (d2_q),
    .out_sb (d2_sb)
  );
  assign {d2_ts, d2_err, d2_big} = d2_sb;

  // Stage 9: raw pressure and the first correction products.
  logic        s9_v_r, s9_err_r;
  logic [31:0] s9_p_r, s9_sqr_r, s9_x2_r;
  logic [15:0] s9_ts_r;
  logic [31:0] s9_p, s9_hi, s9_lin;
  assign s9_p   = d2_big ? {d2_q[30:0], 1'b0} : d2_q;
  assign s9_hi  = asr(s9_p, 8);
  assign s9_lin = P_LIN_COEF * s9_p;

  // Stage 10: quadratic correction term.
  logic        s10_v_r, s10_err_r;
  logic [31:0] s10_p_r, s10_t_r, s10_x2_r;
  logic [15:0] s10_ts_r;
  logic [31:0] s10_prod;
  assign s10_prod = s9_sqr_r * P_SQ_COEF;

  // Output stage: final correction, saturation and the zero-divisor case.
  out_t        out_r;
  logic [31:0] o_p;
  out_t        o_nxt;
  always_comb begin
    o_p = s10_p_r + asr(s10_t_r + s10_x2_r + P_OFFSET, 4);
    o_nxt.temperature_tenths = s10_ts_r;
    o_nxt.divide_error       = s10_err_r;
    if ($signed(o_p) < 0) begin
      o_nxt.pressure_pa = '0;
    end else if ($signed(o_p) > P_MAX) begin
      o_nxt.pressure_pa = P_MAX[16:0];
    end else begin
      o_nxt.pressure_pa = o_p[16:0];
    end
    if (s10_err_r) begin
      o_nxt.temperature_tenths = '0;
      o_nxt.pressure_pa        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= d1_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= d2_v;
      s10_v_r <= s9_v_r;
      out_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1_r   <= asr(s1_prod, 15);
      s1_up_r   <= in_data.raw_pressure;

      s2_x1_r   <= s1_x1_r;
      s2_up_r   <= s1_up_r;
      s2_err_r  <= (s2_den == 32'd0);
      s2_neg_r  <= s2_num[31] ^ s2_den[31];
      s2_nmag_r <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
      s2_dmag_r <= s2_den[31] ? (32'd0 - s2_den) : s2_den;

      s3_b6_r   <= s3_b5 - B6_BIAS;
      s3_ts_r   <= s3_ts;
      s3_up_r   <= d1_up;
      s3_err_r  <= d1_err;

      s4_sq_r   <= asr(s4_b6sq, 12);
      s4_m2_r   <= coef.ac2 * s3_b6_r;
      s4_m3_r   <= coef.ac3 * s3_b6_r;
      s4_ts_r   <= s3_ts_r;
      s4_up_r   <= s3_up_r;
      s4_err_r  <= s3_err_r;

      s5_x3_r   <= asr(s5_p2, 11) + asr(s4_m2_r, 11);
      s5_xs_r   <= asr(s4_m3_r, 13) + asr(s5_p1, 16);
      s5_ts_r   <= s4_ts_r;
      s5_up_r   <= s4_up_r;
      s5_err_r  <= s4_err_r;

      s6_b3_r   <= asr(s6_sum + (s6_sum[31] ? 32'd3 : 32'd0), 2);
      s6_x3_r   <= asr(s5_xs_r + 32'd2, 2);
      s6_ts_r   <= s5_ts_r;
      s6_up_r   <= s5_up_r;
      s6_err_r  <= s5_err_r;

      s7_b4_r   <= {15'd0, s7_b4p[31:15]};
      s7_b7_r   <= s7_b7;
      s7_ts_r   <= s6_ts_r;
      s7_err_r  <= s6_err_r;

      s8_big_r  <= s7_b7_r[31];
      s8_dvd_r  <= s7_b7_r[31] ? s7_b7_r : {s7_b7_r[30:0], 1'b0};
      s8_b4_r   <= s7_b4_r;
      s8_ts_r   <= s7_ts_r;
      s8_err_r  <= s7_err_r || (s7_b4_r == 32'd0);

      s9_p_r    <= s9_p;
      s9_sqr_r  <= s9_hi * s9_hi;
      s9_x2_r   <= asr(s9_lin, 16);
      s9_ts_r   <= d2_ts;
      s9_err_r  <= d2_err;

      s10_p_r   <= s9_p_r;
      s10_t_r   <= asr(s10_prod, 16);
      s10_x2_r  <= s9_x2_r;
      s10_ts_r  <= s9_ts_r;
      s10_err_r <= s9_err_r;

      out_r     <= o_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/bsc_regs.sv =====
module bsc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bsc_pkg::DATA_W-1:0]   pwdata,
  output logic [bsc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bsc_pkg::coef_t               coef
);
  import bsc_pkg::*;

  logic [DATA_W-1:0] regs_r [NUM_REGS];
  logic [2:0]        idx;
  logic              wr_en;
  logic [DATA_W-1:0] wr_val;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // The two packed registers keep all 32 bits; the rest keep 16.
  always_comb begin
    if (idx == REG_AC56 || idx == REG_MCMD) begin
      wr_val = pwdata;
    end else begin
      wr_val = {16'd0, pwdata[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (wr_en) begin
      regs_r[idx] <= wr_val;
    end
  end

  assign prdata = regs_r[idx];

  always_comb begin
    coef.ac1 = sext16(regs_r[REG_AC1][15:0]);
    coef.ac2 = sext16(regs_r[REG_AC2][15:0]);
    coef.ac3 = sext16(regs_r[REG_AC3][15:0]);
    coef.ac4 = {16'd0, regs_r[REG_AC4][15:0]};
    coef.ac5 = {16'd0, regs_r[REG_AC56][31:16]};
    coef.ac6 = {16'd0, regs_r[REG_AC56][15:0]};
    coef.b1  = sext16(regs_r[REG_B1][15:0]);
    coef.b2  = sext16(regs_r[REG_B2][15:0]);
    coef.mc  = sext16(regs_r[REG_MCMD][31:16]);
    coef.md  = sext16(regs_r[REG_MCMD][15:0]);
  end

endmodule

// ===== hdl/bsc_div.sv =====
module bsc_div #(
  parameter int DW  = bsc_pkg::DIV_W,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [DW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_v,
  output logic [DW-1:0]  quo,
  output logic [SBW-1:0] out_sb
);
  // Restoring division, one quotient bit per stage.  nq holds the dividend
  // bits not yet consumed in its upper part and quotient bits in its lower.
  logic           v_r   [DW];
  logic [DW-1:0]  rem_r [DW];
  logic [DW-1:0]  nq_r  [DW];
  logic [DW-1:0]  den_r [DW];
  logic [SBW-1:0] sb_r  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0]  rem_in, nq_in, den_in;
    logic [SBW-1:0] sb_in;
    logic           v_in;
    logic [DW:0]    trial;
    logic [DW:0]    diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign sb_in  = in_sb;
      assign v_in   = in_v;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign v_in   = v_r[k-1];
    end

    assign trial = {rem_in, nq_in[DW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        sb_r[k]  <= sb_in;
        if (!diff[DW]) begin
          rem_r[k] <= diff[DW-1:0];
          nq_r[k]  <= {nq_in[DW-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[DW-1:0];
          nq_r[k]  <= {nq_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v  = v_r[DW-1];
  assign quo    = nq_r[DW-1];
  assign out_sb = sb_r[DW-1];

endmodule

// ===== hdl/bsc_checker.sv =====
module bsc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input bsc_pkg::out_t out_data
);
  import bsc_pkg::*;

  // A result that waits on the output keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input side stalls exactly when a result waits at the output.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // A zero divisor yields zero temperature and pressure.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |->
      out_data.pressure_pa == '0 && out_data.temperature_tenths == '0)
    else $error("divide error with nonzero outputs");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bsc_pkg::*;

  localparam int LATENCY = 75;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  barometric_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the calibration registers, masked like the hardware.
  logic [31:0] calib [NUM_REGS];

  in_t  pending_readings [$];
  out_t expected_results [$];
  int   failures = 0;
  bit   calm = 1'b0;        // no random idling while set
  bit   hold_output = 1'b0; // long receiver hold-off request
  int   hold_count = 0;     // cycles of hold-off spent by the receiver
  bit   in_taken = 1'b0;    // the input transfer completed at the last rising edge
  int   idle_cycles = 0;

  function automatic logic [31:0] shr_arith(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Integer compensation at oversampling setting zero, 32-bit wrapping.
  function automatic out_t compensate(in_t rd);
    out_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p;
    longint ts, ps;
    ac1 = ext16(calib[REG_AC1][15:0]);
    ac2 = ext16(calib[REG_AC2][15:0]);
    ac3 = ext16(calib[REG_AC3][15:0]);
    ac4 = {16'd0, calib[REG_AC4][15:0]};
    ac5 = {16'd0, calib[REG_AC56][31:16]};
    ac6 = {16'd0, calib[REG_AC56][15:0]};
    b1  = ext16(calib[REG_B1][15:0]);
    b2  = ext16(calib[REG_B2][15:0]);
    mc  = ext16(calib[REG_MCMD][31:16]);
    md  = ext16(calib[REG_MCMD][15:0]);
    r = '0;
    x1 = shr_arith(({16'd0, rd.raw_temperature} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    ts = longint'($signed(shr_arith(b5 + 32'd8, 4)));
    b6 = b5 - 32'd4000;
    sq = shr_arith(b6 * b6, 12);
    x1 = shr_arith(b2 * sq, 11);
    x2 = shr_arith(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
    x1 = shr_arith(ac3 * b6, 13);
    x2 = shr_arith(b1 * sq, 16);
    x3 = shr_arith(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.divide_error = 1'b1;
      return r;
    end
    b7 = ({16'd0, rd.raw_pressure} - b3) * 32'd50000;
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = shr_arith(p, 8);
    x1 = x1 * x1;
    x1 = shr_arith(x1 * 32'd3038, 16);
    x2 = shr_arith(32'hFFFF_E331 * p, 16);
    p = p + shr_arith(x1 + x2 + 32'd3791, 4);
    ps = longint'($signed(p));
    if (ps < 0) ps = 0;
    if (ps > 131071) ps = 131071;
    if (ts < -32768) ts = -32768;
    if (ts > 32767) ts = 32767;
    r.temperature_tenths = ts[15:0];
    r.pressure_pa = ps[16:0];
    return r;
  endfunction

  // Driver: offers the next pending reading; the payload is held until it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // keep offering the same transfer
      end else if (pending_readings.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        in_valid <= 1'b1;
        in_data <= pending_readings.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or held high for a counted hold-off stretch.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_output && hold_count < HOLD_CYCLES) begin
        hold_count <= hold_count + 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(99) < 7;
      end
    end
  end

  // Monitor: predicts on input transfers, checks on result transfers.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.push_back(compensate(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer %p", out_data);
          failures++;
        end else begin
          out_t want;
          want = expected_results.pop_front();
          if (out_data.temperature_tenths !== want.temperature_tenths) begin
            $error("temperature_tenths expected %0d actual %0d",
                   want.temperature_tenths, out_data.temperature_tenths);
            failures++;
          end
          if (out_data.pressure_pa !== want.pressure_pa) begin
            $error("pressure_pa expected %0d actual %0d",
                   want.pressure_pa, out_data.pressure_pa);
            failures++;
          end
          if (out_data.divide_error !== want.divide_error) begin
            $error("divide_error expected %0d actual %0d",
                   want.divide_error, out_data.divide_error);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog over cycles without any transfer. A long hold-off is excluded.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_output
        || (pending_readings.size() == 0 && expected_results.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_calib(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_AC56 || idx == REG_MCMD) calib[idx] = value;
    else calib[idx] = {16'd0, value[15:0]};
  endtask

  task automatic load_calib(input logic [31:0] c [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_calib(3'(i), c[i]);
  endtask

  // Waits for every prediction to be met, then lets the pipeline settle.
  task automatic drain();
    while (pending_readings.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_reading(input logic [15:0] ut, input logic [15:0] up);
    in_t rd;
    rd.raw_temperature = ut;
    rd.raw_pressure = up;
    pending_readings.push_back(rd);
  endtask

  // Random readings, mostly near the sensor's typical range, some full range.
  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) queue_reading(16'($urandom), 16'($urandom));
      else queue_reading(16'($urandom_range(20000, 32000)), 16'($urandom_range(20000, 45000)));
    end
  endtask

  logic [31:0] datasheet_set [NUM_REGS];
  logic [31:0] cal [NUM_REGS];

  initial begin
    datasheet_set = '{32'd408, 32'hFFFF_FE48, 32'hFFFF_C6D1, 32'd32741,
                      {16'd32757, 16'd23153}, 32'd6190, 32'd4,
                      {16'hD4BD, 16'd2868}};
    for (int i = 0; i < NUM_REGS; i++) calib[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With all coefficients at reset zero, every reading is a divide error.
    queue_reading(16'd0, 16'd0);
    queue_reading(16'hFFFF, 16'hFFFF);
    drain();

    // Typical calibration: the reference reading plus field extremes.
    load_calib(datasheet_set);
    queue_reading(16'd27898, 16'd23843);
    queue_reading(16'd0, 16'd0);
    queue_reading(16'hFFFF, 16'hFFFF);
    queue_reading(16'd0, 16'hFFFF);
    queue_reading(16'hFFFF, 16'd0);
    queue_reading(16'h5555, 16'hAAAA);
    queue_reading(16'hAAAA, 16'h5555);
    queue_reading(16'd23153, 16'd40000);
    drain();

    // First divisor zero: X1 is zero when UT equals AC6 and MD is zero.
    cal = datasheet_set;
    cal[REG_MCMD] = {16'hD4BD, 16'd0};
    load_calib(cal);
    queue_reading(16'd23153, 16'd30000);
    queue_reading(16'd23154, 16'd30000);
    drain();

    // Second divisor zero: AC4 zero forces B4 to zero.
    cal = datasheet_set;
    cal[REG_AC4] = 32'd0;
    load_calib(cal);
    queue_reading(16'd27898, 16'd23843);
    drain();

    // Extreme coefficients drive pressure and temperature into saturation.
    load_calib('{32'h0000_7FFF, 32'h0000_8000, 32'h0000_7FFF, 32'h0000_FFFF,
                 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_7FFF, 32'h7FFF_8001});
    queue_reading(16'd0, 16'hFFFF);
    queue_reading(16'hFFFF, 16'd0);
    queue_reading(16'h8000, 16'h8000);
    drain();
    load_calib('{32'h0000_8000, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_0001,
                 32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h8000_7FFF});
    queue_reading(16'd0, 16'hFFFF);
    queue_reading(16'hFFFF, 16'h0000);
    drain();

    // Back pressure: the receiver holds off while the sender keeps offering.
    load_calib(datasheet_set);
    calm = 1'b1;
    hold_output = 1'b1;
    queue_random(200);
    wait (hold_count >= HOLD_CYCLES);
    hold_output = 1'b0;
    drain();

    // Random phases: each with its own calibration, one without idling.
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      for (int i = 0; i < NUM_REGS; i++)
        cal[i] = (phase % 2 == 0) ? datasheet_set[i] ^ ($urandom & 32'h0000_00FF)
                                  : $urandom;
      load_calib(cal);
      queue_random(150);
      drain();
    end

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
